// File: rtl/rgb16_pkg.sv
package rgb16_pkg;

   // Conversion modes, as held in the mode register
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_TINT  = 2'd1,
      MODE_GRAY  = 2'd2,
      MODE_RAMP  = 2'd3
   } mode_type;

   // Pixel layouts
   localparam logic FMT_RGB565 = 1'b0;
   localparam logic FMT_RGB555 = 1'b1;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_FORMAT  = 3'd0;
   localparam logic [2:0] REG_MODE    = 3'd1;
   localparam logic [2:0] REG_TINT_R  = 3'd2;
   localparam logic [2:0] REG_TINT_G  = 3'd3;
   localparam logic [2:0] REG_TINT_B  = 3'd4;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Ramp level carrier: holds levels up to 64
   localparam int unsigned LVL_W = 7;

   // Luma weights and the reciprocal used for the /100
   localparam logic [14:0] GRAY_KR    = 15'd30;
   localparam logic [14:0] GRAY_KG    = 15'd59;
   localparam logic [14:0] GRAY_KB    = 15'd11;
   localparam logic [12:0] GRAY_RECIP = 13'd5243;
   localparam int unsigned GRAY_SHIFT = 19;

   // Input beat
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       final_color;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [15:0] pixel16;
      logic [5:0]  level;
      logic        run_end;
      logic        palette_end;
   } rsp_type;

   // One conversion job from the sequencer
   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      mode_type         mode;
      logic             fmt;
      logic [LVL_W-1:0] lvl;
      logic             run_end;
      logic             palette_end;
   } job_type;

   // Channel products after the first stage
   typedef struct packed {
      logic [15:0] prod_r;
      logic [15:0] prod_g;
      logic [15:0] prod_b;
      logic [14:0] gray_sum;
      mode_type    mode;
      logic        fmt;
      logic [5:0]  level;
      logic        run_end;
      logic        palette_end;
   } prod_type;

   // Pack three 8-bit channels into the selected 16-bit layout
   function automatic logic [15:0] pack16(input logic fmt, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
      logic [15:0] pix;
      if (fmt == FMT_RGB555) begin
         pix = {1'b0, r[7:3], g[7:3], b[7:3]};
      end else begin
         pix = {r[7:3], g[7:2], b[7:3]};
      end
      return pix;
   endfunction

endpackage

// File: rtl/rgb16_seq.sv
module rgb16_seq #(
   parameter int unsigned RAMP_LEVELS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rgb16_pkg::req_type req_payload,
   input  rgb16_pkg::mode_type cfg_mode,
   input  logic              cfg_fmt,
   output logic              job_valid,
   input  logic              job_ready,
   output rgb16_pkg::job_type job
);
   import rgb16_pkg::*;

   localparam logic [LVL_W-1:0] RAMP_TOP = LVL_W'(RAMP_LEVELS);

   logic             valid_ff, valid_in;
   req_type          color_ff, color_in;
   logic             ramp_ff, ramp_in;
   logic             fmt_ff, fmt_in;
   mode_type         mode_ff, mode_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             is_last;
   logic             req_fire;
   logic             job_fire;

   // Last job of the held color: single job, or ramp at level one
   assign is_last   = !ramp_ff || (lvl_ff == LVL_W'(1));
   assign job_valid = valid_ff;
   assign job_fire  = valid_ff && job_ready;
   assign req_ready = !valid_ff || (job_ready && is_last);
   assign req_fire  = req_valid && req_ready;

   // Job fields
   always_comb begin
      job.red         = color_ff.red;
      job.green       = color_ff.green;
      job.blue        = color_ff.blue;
      job.mode        = mode_ff;
      job.fmt         = fmt_ff;
      job.lvl         = ramp_ff ? lvl_ff : RAMP_TOP;
      job.run_end     = is_last;
      job.palette_end = is_last && color_ff.final_color;
   end

   // Load a new color or step the ramp down one level
   always_comb begin
      valid_in = valid_ff;
      color_in = color_ff;
      ramp_in  = ramp_ff;
      fmt_in   = fmt_ff;
      mode_in  = mode_ff;
      lvl_in   = lvl_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         color_in = req_payload;
         ramp_in  = (cfg_mode == MODE_RAMP);
         fmt_in   = cfg_fmt;
         mode_in  = cfg_mode;
         lvl_in   = RAMP_TOP;
      end else if (job_fire) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            lvl_in = lvl_ff - LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      color_ff <= color_in;
      ramp_ff  <= ramp_in;
      fmt_ff   <= fmt_in;
      mode_ff  <= mode_in;
      lvl_ff   <= lvl_in;
   end

endmodule

// File: rtl/rgb16_scale.sv
module rgb16_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  rgb16_pkg::job_type job,
   input  logic [7:0]         tint_r,
   input  logic [7:0]         tint_g,
   input  logic [7:0]         tint_b,
   output logic               prod_valid,
   input  logic               prod_ready,
   output rgb16_pkg::prod_type prod
);
   import rgb16_pkg::*;

   logic       prod_valid_ff, prod_valid_in;
   prod_type   prod_ff, prod_in;
   logic [7:0] fac_r, fac_g, fac_b;

   assign job_ready  = !prod_valid_ff || prod_ready;
   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

   // Per-channel factor: tint, ramp level, or unity
   always_comb begin
      case (job.mode)
         MODE_TINT: begin
            fac_r = tint_r;
            fac_g = tint_g;
            fac_b = tint_b;
         end
         MODE_RAMP: begin
            fac_r = 8'(job.lvl);
            fac_g = 8'(job.lvl);
            fac_b = 8'(job.lvl);
         end
         default: begin
            fac_r = 8'd1;
            fac_g = 8'd1;
            fac_b = 8'd1;
         end
      endcase
   end

   // Products and luma sum
   always_comb begin
      prod_in             = prod_ff;
      prod_valid_in       = prod_valid_ff;
      if (job_ready) begin
         prod_valid_in        = job_valid;
         prod_in.prod_r       = 16'(job.red) * 16'(fac_r);
         prod_in.prod_g       = 16'(job.green) * 16'(fac_g);
         prod_in.prod_b       = 16'(job.blue) * 16'(fac_b);
         prod_in.gray_sum     = 15'(job.red) * GRAY_KR + 15'(job.green) * GRAY_KG
                              + 15'(job.blue) * GRAY_KB;
         prod_in.mode         = job.mode;
         prod_in.fmt          = job.fmt;
         prod_in.level        = job.lvl[5:0];
         prod_in.run_end      = job.run_end;
         prod_in.palette_end  = job.palette_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/rgb16_pack.sv
module rgb16_pack #(
   parameter int unsigned RAMP_LEVELS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                prod_valid,
   output logic                prod_ready,
   input  rgb16_pkg::prod_type prod,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rgb16_pkg::rsp_type  rsp_payload
);
   import rgb16_pkg::*;

   // x / RAMP_LEVELS as (x * RAMP_RECIP) >> RAMP_SHIFT, exact for x < 2^14
   localparam int unsigned RAMP_SHIFT = 20;
   localparam int unsigned RECIP_W    = RAMP_SHIFT + 1;
   localparam int unsigned RPROD_W    = RECIP_W + 14;
   localparam logic [RECIP_W-1:0] RAMP_RECIP =
      RECIP_W'(((2 ** RAMP_SHIFT) + RAMP_LEVELS - 1) / RAMP_LEVELS);

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [RPROD_W-1:0] rp_r, rp_g, rp_b;
   logic [27:0]        gray_prod;
   logic [7:0]         ch_r, ch_g, ch_b;

   // x / 255 for x < 65280, where the quotient fits in 8 bits
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   assign prod_ready  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Reciprocal products
   assign rp_r      = RPROD_W'(prod.prod_r[13:0]) * RPROD_W'(RAMP_RECIP);
   assign rp_g      = RPROD_W'(prod.prod_g[13:0]) * RPROD_W'(RAMP_RECIP);
   assign rp_b      = RPROD_W'(prod.prod_b[13:0]) * RPROD_W'(RAMP_RECIP);
   assign gray_prod = 28'(prod.gray_sum) * 28'(GRAY_RECIP);

   // Final channel values
   always_comb begin
      case (prod.mode)
         MODE_TINT: begin
            ch_r = div255(prod.prod_r);
            ch_g = div255(prod.prod_g);
            ch_b = div255(prod.prod_b);
         end
         MODE_GRAY: begin
            ch_r = gray_prod[GRAY_SHIFT +: 8];
            ch_g = gray_prod[GRAY_SHIFT +: 8];
            ch_b = gray_prod[GRAY_SHIFT +: 8];
         end
         MODE_RAMP: begin
            ch_r = rp_r[RAMP_SHIFT +: 8];
            ch_g = rp_g[RAMP_SHIFT +: 8];
            ch_b = rp_b[RAMP_SHIFT +: 8];
         end
         default: begin
            ch_r = prod.prod_r[7:0];
            ch_g = prod.prod_g[7:0];
            ch_b = prod.prod_b[7:0];
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (prod_ready) begin
         rsp_valid_in       = prod_valid;
         rsp_in.pixel16     = pack16(prod.fmt, ch_r, ch_g, ch_b);
         rsp_in.level       = prod.level;
         rsp_in.run_end     = prod.run_end;
         rsp_in.palette_end = prod.palette_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/rgb888_to_rgb16_palette_convert.sv
// Converts 8-bit-per-channel palette colors to packed RGB565 or RGB555 pixels.
// Plain, tint and gray modes give one result beat per input beat and sustain
// one color per clock while rsp_ready stays high; ramp mode gives RAMP_LEVELS
// beats per color (levels descending, last one flagged run_end), paced by the
// sequencer's level counter that issues one level per cycle unless the output
// stalls. A result passes the sequencer, product and result registers.
// Configuration registers (byte address 4*index): format, mode, tint red,
// tint green, tint blue; write them only while no beats are in flight.
module rgb888_to_rgb16_palette_convert #(
   parameter int unsigned RAMP_LEVELS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rgb16_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rgb16_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rgb16_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rgb16_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rgb16_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import rgb16_pkg::*;

   logic       fmt_ff, fmt_in;
   mode_type   mode_ff, mode_in;
   logic [7:0] tint_r_ff, tint_r_in;
   logic [7:0] tint_g_ff, tint_g_in;
   logic [7:0] tint_b_ff, tint_b_in;
   logic       csr_wr;
   logic [2:0] csr_idx;

   logic       job_valid, job_ready;
   job_type    job;
   logic       prod_valid, prod_ready;
   prod_type   prod;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      fmt_in    = fmt_ff;
      mode_in   = mode_ff;
      tint_r_in = tint_r_ff;
      tint_g_in = tint_g_ff;
      tint_b_in = tint_b_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FORMAT: fmt_in    = csr_pwdata[0];
            REG_MODE:   mode_in   = mode_type'(csr_pwdata[1:0]);
            REG_TINT_R: tint_r_in = csr_pwdata[7:0];
            REG_TINT_G: tint_g_in = csr_pwdata[7:0];
            REG_TINT_B: tint_b_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FORMAT: csr_prdata = CSR_DATA_W'(fmt_ff);
         REG_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         REG_TINT_R: csr_prdata = CSR_DATA_W'(tint_r_ff);
         REG_TINT_G: csr_prdata = CSR_DATA_W'(tint_g_ff);
         REG_TINT_B: csr_prdata = CSR_DATA_W'(tint_b_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_RGB565;
         mode_ff   <= MODE_PLAIN;
         tint_r_ff <= 8'd255;
         tint_g_ff <= 8'd255;
         tint_b_ff <= 8'd255;
      end else begin
         fmt_ff    <= fmt_in;
         mode_ff   <= mode_in;
         tint_r_ff <= tint_r_in;
         tint_g_ff <= tint_g_in;
         tint_b_ff <= tint_b_in;
      end
   end

   // Datapath
   rgb16_seq #(.RAMP_LEVELS(RAMP_LEVELS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg_mode    (mode_ff),
      .cfg_fmt     (fmt_ff),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   rgb16_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .tint_r     (tint_r_ff),
      .tint_g     (tint_g_ff),
      .tint_b     (tint_b_ff),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   rgb16_pack #(.RAMP_LEVELS(RAMP_LEVELS)) u_pack (
      .clock       (clock),
      .reset       (reset),
      .prod_valid  (prod_valid),
      .prod_ready  (prod_ready),
      .prod        (prod),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Checks
   a_pal_end_on_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.palette_end |-> rsp_payload.run_end)
      else $error("palette_end without run_end");

   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job.run_end |-> !req_ready)
      else $error("input taken while a ramp run is still issuing");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !job_valid)
      else $error("beat pending right after reset");

endmodule

// File: tb/sv/rgb888_to_rgb16_palette_convert_tb.sv
module rgb888_to_rgb16_palette_convert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rgb16_pkg::*;

   localparam int unsigned RAMP_STEPS  = 32;
   localparam int unsigned TOTAL_ITEMS = 416;
   localparam int unsigned TAIL_CYCLES = 12;
   localparam int unsigned MAX_PRINTS  = 40;
   localparam longint     TIMEOUT_NS  = 64'd20_000_000;

   // addresses past the register list, must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the block's registers
   logic       cfg_fmt  = FMT_RGB565;
   mode_type   cfg_mode = MODE_PLAIN;
   logic [7:0] tint_r   = 8'd255;
   logic [7:0] tint_g   = 8'd255;
   logic [7:0] tint_b   = 8'd255;

   req_type colors_to_send[$];
   rsp_type pixels_due[$];
   int unsigned colors_queued = 0;
   int unsigned colors_taken  = 0;
   int unsigned error_count   = 0;

   logic        req_beat_done = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned seg_left   = 0;
   int unsigned run_left   = 0;
   int unsigned stall_kind = 0;

   rgb888_to_rgb16_palette_convert #(
      .RAMP_LEVELS(RAMP_STEPS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // 16-bit packing: 565 keeps 6 green bits, 555 drops the top bit
   function automatic logic [15:0] pack_rgb16(input logic fmt, input int unsigned r,
                                              input int unsigned g, input int unsigned b);
      int unsigned word;
      if (fmt == FMT_RGB555) begin
         word = ((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3);
      end else begin
         word = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
      end
      return word[15:0];
   endfunction

   // expected pixels for one accepted color under the current settings
   task automatic expand_color(input req_type c);
      int unsigned r;
      int unsigned g;
      int unsigned b;
      int unsigned gray;
      int unsigned lvl;
      rsp_type px;
      r = c.red;
      g = c.green;
      b = c.blue;
      if (cfg_mode == MODE_RAMP) begin
         for (lvl = RAMP_STEPS; lvl > 0; lvl--) begin
            px.pixel16     = pack_rgb16(cfg_fmt, r * lvl / RAMP_STEPS, g * lvl / RAMP_STEPS,
                                        b * lvl / RAMP_STEPS);
            px.level       = lvl[5:0];
            px.run_end     = (lvl == 1);
            px.palette_end = (lvl == 1) && c.final_color;
            pixels_due.push_back(px);
         end
      end else begin
         case (cfg_mode)
            MODE_TINT: begin
               px.pixel16 = pack_rgb16(cfg_fmt, r * tint_r / 255, g * tint_g / 255,
                                       b * tint_b / 255);
            end
            MODE_GRAY: begin
               gray = (r * 30 + g * 59 + b * 11) / 100;
               px.pixel16 = pack_rgb16(cfg_fmt, gray, gray, gray);
            end
            default: begin
               px.pixel16 = pack_rgb16(cfg_fmt, r, g, b);
            end
         endcase
         lvl            = RAMP_STEPS;
         px.level       = lvl[5:0];
         px.run_end     = 1'b1;
         px.palette_end = c.final_color;
         pixels_due.push_back(px);
      end
   endtask

   // input side: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat_done) begin
         // beat still waiting for ready
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (colors_to_send.size() > 0) begin
         req_valid   <= 1'b1;
         req_payload <= colors_to_send.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side: stall pattern changes every segment
   always @(negedge clock) begin
      if (seg_left == 0) begin
         stall_kind <= $urandom_range(0, 3);
         seg_left   <= $urandom_range(20, 200);
      end else begin
         seg_left <= seg_left - 1;
      end
      case (stall_kind)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ~rsp_ready;
         default: begin
            if (run_left == 0) begin
               rsp_ready <= ~rsp_ready;
               run_left  <= rsp_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   // accept colors into the prediction, check result beats in order
   always @(posedge clock) begin : check_results
      rsp_type want;
      req_beat_done <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expand_color(req_payload);
            colors_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat pixel16=%h level=%0d",
                                         rsp_payload.pixel16, rsp_payload.level));
            end else begin
               want = pixels_due.pop_front();
               if (rsp_payload.pixel16 !== want.pixel16)
                  report_mismatch($sformatf("pixel16 got %h want %h",
                                            rsp_payload.pixel16, want.pixel16));
               if (rsp_payload.level !== want.level)
                  report_mismatch($sformatf("level got %0d want %0d",
                                            rsp_payload.level, want.level));
               if (rsp_payload.run_end !== want.run_end)
                  report_mismatch($sformatf("run_end got %b want %b (level %0d)",
                                            rsp_payload.run_end, want.run_end, want.level));
               if (rsp_payload.palette_end !== want.palette_end)
                  report_mismatch($sformatf("palette_end got %b want %b (level %0d)",
                                            rsp_payload.palette_end, want.palette_end,
                                            want.level));
            end
         end
      end
   end

   // read one register back and compare with the shadow copy
   task automatic csr_check(input logic [2:0] idx);
      logic [31:0] want;
      logic [31:0] got;
      case (idx)
         REG_FORMAT: want = {31'd0, cfg_fmt};
         REG_MODE:   want = {30'd0, cfg_mode};
         REG_TINT_R: want = {24'd0, tint_r};
         REG_TINT_G: want = {24'd0, tint_g};
         default:    want = {24'd0, tint_b};
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want)
         report_mismatch($sformatf("register %0d read %h want %h", idx, got, want));
   endtask

   // setup + access write; upper data bits are junk and must be masked
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_FORMAT: cfg_fmt  = value[0];
         REG_MODE:   cfg_mode = mode_type'(value[1:0]);
         REG_TINT_R: tint_r   = value[7:0];
         REG_TINT_G: tint_g   = value[7:0];
         REG_TINT_B: tint_b   = value[7:0];
         default: ;
      endcase
      if (idx <= REG_TINT_B) csr_check(idx);
   endtask

   task automatic queue_color(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fin);
      req_type c;
      c.red         = r;
      c.green       = g;
      c.blue        = b;
      c.final_color = fin;
      colors_to_send.push_back(c);
      colors_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (colors_taken != colors_queued || pixels_due.size() != 0);
   endtask

   // channel values lean toward the extremes
   function automatic logic [7:0] pick_channel();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_tint();
      int unsigned sel;
      sel = $urandom_range(0, 5);
      if (sel == 0) return 8'd0;
      if (sel == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   initial begin : stimulus
      int unsigned n_items;
      int unsigned k;
      mode_type    m;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of all registers
      for (k = 0; k <= REG_TINT_B; k++) csr_check(k[2:0]);

      // plain 565: extremes and truncation boundaries
      queue_color(8'h00, 8'h00, 8'h00, 1'b0);
      queue_color(8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_color(8'h07, 8'h03, 8'h07, 1'b0);
      queue_color(8'h08, 8'h04, 8'h08, 1'b0);
      queue_color(8'hAA, 8'h55, 8'hAA, 1'b0);
      wait_drained();

      // tint 555 with zero, full and half factors
      csr_write(REG_FORMAT, 32'({$urandom, 1'b1}));
      csr_write(REG_MODE, 32'({$urandom, MODE_TINT}));
      csr_write(REG_TINT_R, 32'({$urandom, 8'd0}));
      csr_write(REG_TINT_G, 32'({$urandom, 8'd255}));
      csr_write(REG_TINT_B, 32'({$urandom, 8'd128}));
      queue_color(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_color(8'h80, 8'hFF, 8'h01, 1'b1);
      queue_color(8'hFF, 8'h7F, 8'hFF, 1'b0);
      wait_drained();

      // writes past the register list leave everything as is
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);

      // gray 555: pure primaries and the full-scale sum
      csr_write(REG_MODE, 32'({$urandom, MODE_GRAY}));
      queue_color(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_color(8'hFF, 8'h00, 8'h00, 1'b0);
      queue_color(8'h00, 8'hFF, 8'h00, 1'b0);
      queue_color(8'h00, 8'h00, 8'hFF, 1'b1);
      queue_color(8'h01, 8'h01, 8'h01, 1'b0);
      wait_drained();

      // ramp 565: full run of levels, back to back
      csr_write(REG_FORMAT, 32'({$urandom, 1'b0}));
      csr_write(REG_MODE, 32'({$urandom, MODE_RAMP}));
      queue_color(8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_color(8'h01, 8'h7F, 8'h80, 1'b0);
      queue_color(8'h00, 8'h00, 8'h00, 1'b0);
      wait_drained();

      // random phases, each with a fresh setting
      while (colors_queued < TOTAL_ITEMS) begin
         m = mode_type'($urandom_range(0, 3));
         csr_write(REG_FORMAT, $urandom);
         csr_write(REG_MODE, 32'({$urandom, m}));
         csr_write(REG_TINT_R, 32'({$urandom, pick_tint()}));
         csr_write(REG_TINT_G, 32'({$urandom, pick_tint()}));
         csr_write(REG_TINT_B, 32'({$urandom, pick_tint()}));
         n_items = (m == MODE_RAMP) ? $urandom_range(6, 16) : $urandom_range(25, 50);
         for (k = 0; k < n_items; k++) begin
            queue_color(pick_channel(), pick_channel(), pick_channel(),
                        $urandom_range(0, 5) == 0);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** rgb888_to_rgb16_palette_convert: PASSED **");
      end else begin
         $display("** rgb888_to_rgb16_palette_convert: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("** rgb888_to_rgb16_palette_convert: FAILED **");
      $finish;
   end

endmodule
